// File: hw/rtl/cube_range_sum_engine_top_macros.svh
// Assertion macros shared by the cube range-sum engine RTL.
`ifndef CUBE_RANGE_SUM_ENGINE_TOP_MACROS_SVH
`define CUBE_RANGE_SUM_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CRES_CHECK_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CRES_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cres_pkg.sv
// Shared constants, types and helpers of the cube range-sum engine.
package cres_pkg;

   localparam int SIDE     = 8;
   localparam int COORD_W  = 4;
   localparam int VALUE_W  = 16;
   localparam int PREFIX_W = 22;
   localparam int TOTAL_W  = 25;

   localparam int DEPTH  = SIDE * SIDE * SIDE;
   localparam int IDX_W  = (SIDE > 1) ? $clog2(SIDE) : 1;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int POS_W  = ADDR_W;
   localparam int SIDE_W = $clog2(SIDE + 1);
   localparam int SQ_W   = $clog2(SIDE * SIDE + 1);
   localparam int CUBE_W = $clog2(DEPTH + 1);
   localparam int CMP_W  = (COORD_W > SIDE_W) ? COORD_W : SIDE_W;

   // Request tdata layout, lowest bit first.
   localparam int ELEM_LSB   = 0;
   localparam int LAYER_L_LSB = ELEM_LSB + VALUE_W;
   localparam int LAYER_H_LSB = LAYER_L_LSB + COORD_W;
   localparam int ROW_L_LSB  = LAYER_H_LSB + COORD_W;
   localparam int ROW_H_LSB  = ROW_L_LSB + COORD_W;
   localparam int COL_L_LSB  = ROW_H_LSB + COORD_W;
   localparam int COL_H_LSB  = COL_L_LSB + COORD_W;
   localparam int REQ_DATA_W = ((COL_H_LSB + COORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((TOTAL_W + 7) / 8) * 8;

   localparam int SETTLE_W = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] LOAD_LAST_STEP  = 2'd2;
   localparam logic [STEP_W-1:0] QUERY_LAST_STEP = 2'd3;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SYNC_LAYER,
      ST_SYNC_ROW,
      ST_LOAD_RD,
      ST_LOAD_DRAIN,
      ST_LOAD_WR,
      ST_QUERY_RD,
      ST_QUERY_DRAIN,
      ST_QUERY_OUT
   } state_type;

   // Flat address of (layer, row, column), all zero-based.
   function automatic logic [ADDR_W-1:0] make_addr(input logic [IDX_W-1:0] l,
                                                   input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return ADDR_W'((int'(l) * SIDE + int'(r)) * SIDE + int'(c));
   endfunction

endpackage

// File: hw/rtl/cres_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cres_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/cres_alu.sv
// Shared add/subtract unit with borrow, used for sums and position splitting.
module cres_alu (
   input  logic [cres_pkg::TOTAL_W-1:0] a,
   input  logic [cres_pkg::TOTAL_W-1:0] b,
   input  logic                         sub,
   output logic [cres_pkg::TOTAL_W-1:0] y,
   output logic                         borrow
);
   import cres_pkg::*;

   logic [TOTAL_W:0] wide;

   always_comb begin
      if (sub) begin
         wide = {1'b0, a} - {1'b0, b};
      end else begin
         wide = {1'b0, a} + {1'b0, b};
      end
   end

   assign y      = wide[TOTAL_W-1:0];
   // The top bit of an unsigned difference is set exactly when a < b.
   assign borrow = sub & wide[TOTAL_W];

endmodule

// File: hw/rtl/cube_range_sum_engine_top.sv
// Top level of the cube range-sum engine: sequencer, prefix store and output register.
//
//   Channel  Dir  Handshake             Payload
//   req      in   req_tvalid/tready     tuser: kind; tdata: value and six box bounds
//   rsp      out  rsp_tvalid/tready     tdata: range total; tuser: bad-query flag
//   csr      in   csr_we                csr_wdata: cube edge length
//
// A load goes from transfer to prefix write through three prefix reads, one drain and
// one write; after an edge-length write the first load splits the load position into
// layer, row and column by repeated subtraction (or restarts at zero if outside the cube).
// A query reads four prefix terms per layer of the box through the single RAM read port,
// then drains and fills the output register; a bad or empty box goes straight to output.
// Reset is synchronous; the prefix store is not cleared. After a csr write the request
// side stays not ready while the square and cube of the edge settle.
// A result waits in the output register; the block accepts the next request meanwhile
// and only stalls a second query at its final cycle until that register is free.
module cube_range_sum_engine_top (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: elem_value, layer_low, layer_high, row_low, row_high, col_low, col_high.
   input  logic [cres_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: req_type.
   input  logic                              req_tuser,
   // Result channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: range_total, zero padded.
   output logic [cres_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: bad_query.
   output logic                              rsp_tuser,
   // Configuration.
   input  logic                              csr_we,
   input  logic [cres_pkg::COORD_W-1:0]      csr_wdata
);
   import cres_pkg::*;

   `include "cube_range_sum_engine_top_macros.svh"

   state_type state_ff, state_in;

   logic [COORD_W-1:0]  side_ff, side_in;
   logic [SIDE_W-1:0]   eff;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [CUBE_W-1:0]   cube_ff, cube_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic                resync_ff, resync_in;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    l_ff, l_in;
   logic [IDX_W-1:0]    r_ff, r_in;
   logic [IDX_W-1:0]    c_ff, c_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [TOTAL_W-1:0]  acc_ff, acc_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [IDX_W-1:0]    ly_ff, ly_in;
   logic [IDX_W-1:0]    ly_end_ff, ly_end_in;
   logic [IDX_W-1:0]    rh_ff, rh_in;
   logic [IDX_W-1:0]    rl_ff, rl_in;
   logic [IDX_W-1:0]    ch_ff, ch_in;
   logic [IDX_W-1:0]    cl_ff, cl_in;
   logic                rl_one_ff, rl_one_in;
   logic                cl_one_ff, cl_one_in;
   logic                bad_ff, bad_in;

   logic                rd_pend_ff, rd_pend_in;
   logic                rd_zero_ff, rd_zero_in;
   logic                rd_sub_ff, rd_sub_in;

   logic                out_valid_ff, out_valid_in;
   logic [TOTAL_W-1:0]  out_total_ff, out_total_in;
   logic                out_bad_ff, out_bad_in;

   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [PREFIX_W-1:0] ram_rdata;

   logic [TOTAL_W-1:0]  alu_b, alu_y;
   logic                alu_sub, alu_borrow;

   logic [COORD_W-1:0]  bnd [6];
   logic                req_fire;
   logic                any_bad, empty_box;
   logic [CUBE_W-1:0]   pos_next;
   logic [SIDE_W-1:0]   eff_last;
   logic [IDX_W-1:0]    term_l, term_r, term_c;
   logic                term_zero, term_sub;

   cres_ram #(
      .WIDTH (PREFIX_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (acc_ff[PREFIX_W-1:0]),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   cres_alu u_alu (
      .a      (acc_ff),
      .b      (alu_b),
      .sub    (alu_sub),
      .y      (alu_y),
      .borrow (alu_borrow)
   );

   // Edge lengths of zero and above the cube size act as one and the cube size.
   always_comb begin
      priority if (side_ff == '0) begin
         eff = SIDE_W'(1);
      end else if (CMP_W'(side_ff) > CMP_W'(SIDE)) begin
         eff = SIDE_W'(SIDE);
      end else begin
         eff = SIDE_W'(side_ff);
      end
   end

   assign eff_last = SIDE_W'(eff - SIDE_W'(1));
   assign sq_in    = SQ_W'(SQ_W'(eff) * SQ_W'(eff));
   assign cube_in  = CUBE_W'(CUBE_W'(sq_ff) * CUBE_W'(eff));

   assign req_tready = (state_ff == ST_IDLE) && (settle_ff == '0);
   assign req_fire   = req_tvalid && req_tready;

   assign bnd[0] = req_tdata[LAYER_L_LSB +: COORD_W];
   assign bnd[1] = req_tdata[LAYER_H_LSB +: COORD_W];
   assign bnd[2] = req_tdata[ROW_L_LSB +: COORD_W];
   assign bnd[3] = req_tdata[ROW_H_LSB +: COORD_W];
   assign bnd[4] = req_tdata[COL_L_LSB +: COORD_W];
   assign bnd[5] = req_tdata[COL_H_LSB +: COORD_W];

   always_comb begin
      any_bad = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (bnd[i] == '0 || CMP_W'(bnd[i]) > CMP_W'(eff)) begin
            any_bad = 1'b1;
         end
      end
   end

   assign empty_box = (bnd[0] > bnd[1]) || (bnd[2] > bnd[3]) || (bnd[4] > bnd[5]);
   assign pos_next  = CUBE_W'(pos_ff) + CUBE_W'(1);

   // Address and sign of the prefix term issued at the current step.
   always_comb begin
      term_l    = l_ff;
      term_r    = r_ff;
      term_c    = c_ff;
      term_zero = 1'b0;
      term_sub  = 1'b0;
      if (state_ff == ST_QUERY_RD) begin
         term_l = ly_ff;
         unique case (step_ff)
            2'd0: begin
               term_r = rh_ff;
               term_c = ch_ff;
            end
            2'd1: begin
               term_r    = rl_ff;
               term_c    = ch_ff;
               term_zero = rl_one_ff;
               term_sub  = 1'b1;
            end
            2'd2: begin
               term_r    = rh_ff;
               term_c    = cl_ff;
               term_zero = cl_one_ff;
               term_sub  = 1'b1;
            end
            default: begin
               term_r    = rl_ff;
               term_c    = cl_ff;
               term_zero = rl_one_ff || cl_one_ff;
            end
         endcase
      end else begin
         unique case (step_ff)
            2'd0: begin
               term_r    = IDX_W'(r_ff - IDX_W'(1));
               term_zero = (r_ff == '0);
            end
            2'd1: begin
               term_c    = IDX_W'(c_ff - IDX_W'(1));
               term_zero = (c_ff == '0);
            end
            default: begin
               term_r    = IDX_W'(r_ff - IDX_W'(1));
               term_c    = IDX_W'(c_ff - IDX_W'(1));
               term_zero = (r_ff == '0) || (c_ff == '0);
               term_sub  = 1'b1;
            end
         endcase
      end
   end

   assign ram_raddr = make_addr(term_l, term_r, term_c);
   assign ram_waddr = make_addr(l_ff, r_ff, c_ff);

   // The shared unit either folds in a prefix term or peels a layer or row off the position.
   always_comb begin
      unique case (state_ff)
         ST_SYNC_LAYER: begin
            alu_b   = TOTAL_W'(sq_ff);
            alu_sub = 1'b1;
         end
         ST_SYNC_ROW: begin
            alu_b   = TOTAL_W'(eff);
            alu_sub = 1'b1;
         end
         default: begin
            alu_b   = rd_zero_ff ? '0 : TOTAL_W'(ram_rdata);
            alu_sub = rd_sub_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      settle_in    = (settle_ff != '0) ? SETTLE_W'(settle_ff - SETTLE_W'(1)) : settle_ff;
      resync_in    = resync_ff;
      pos_in       = pos_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      val_in       = val_ff;
      acc_in       = rd_pend_ff ? alu_y : acc_ff;
      step_in      = step_ff;
      ly_in        = ly_ff;
      ly_end_in    = ly_end_ff;
      rh_in        = rh_ff;
      rl_in        = rl_ff;
      ch_in        = ch_ff;
      cl_in        = cl_ff;
      rl_one_in    = rl_one_ff;
      cl_one_in    = cl_one_ff;
      bad_in       = bad_ff;
      rd_pend_in   = 1'b0;
      rd_zero_in   = term_zero;
      rd_sub_in    = term_sub;
      ram_re       = 1'b0;
      ram_we       = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_total_in = out_total_ff;
      out_bad_in   = out_bad_ff;

      if (csr_we) begin
         side_in   = csr_wdata;
         settle_in = SETTLE_CYCLES;
         resync_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               val_in  = req_tdata[ELEM_LSB +: VALUE_W];
               step_in = '0;
               if (req_kind_type'(req_tuser) == REQ_LOAD) begin
                  acc_in = TOTAL_W'(req_tdata[ELEM_LSB +: VALUE_W]);
                  priority if (resync_ff && CUBE_W'(pos_ff) >= cube_ff) begin
                     pos_in    = '0;
                     l_in      = '0;
                     r_in      = '0;
                     c_in      = '0;
                     resync_in = 1'b0;
                     state_in  = ST_LOAD_RD;
                  end else if (resync_ff) begin
                     acc_in   = TOTAL_W'(pos_ff);
                     l_in     = '0;
                     state_in = ST_SYNC_LAYER;
                  end else begin
                     state_in = ST_LOAD_RD;
                  end
               end else begin
                  acc_in    = '0;
                  bad_in    = any_bad;
                  ly_in     = IDX_W'(bnd[0] - COORD_W'(1));
                  ly_end_in = IDX_W'(bnd[1] - COORD_W'(1));
                  rl_in     = IDX_W'(bnd[2] - COORD_W'(2));
                  rh_in     = IDX_W'(bnd[3] - COORD_W'(1));
                  cl_in     = IDX_W'(bnd[4] - COORD_W'(2));
                  ch_in     = IDX_W'(bnd[5] - COORD_W'(1));
                  rl_one_in = (bnd[2] == COORD_W'(1));
                  cl_one_in = (bnd[4] == COORD_W'(1));
                  state_in  = (any_bad || empty_box) ? ST_QUERY_OUT : ST_QUERY_RD;
               end
            end
         end
         ST_SYNC_LAYER: begin
            if (!alu_borrow) begin
               acc_in = alu_y;
               l_in   = IDX_W'(l_ff + IDX_W'(1));
            end else begin
               r_in     = '0;
               state_in = ST_SYNC_ROW;
            end
         end
         ST_SYNC_ROW: begin
            if (!alu_borrow) begin
               acc_in = alu_y;
               r_in   = IDX_W'(r_ff + IDX_W'(1));
            end else begin
               c_in      = acc_ff[IDX_W-1:0];
               resync_in = 1'b0;
               acc_in    = TOTAL_W'(val_ff);
               state_in  = ST_LOAD_RD;
            end
         end
         ST_LOAD_RD: begin
            ram_re     = 1'b1;
            rd_pend_in = 1'b1;
            step_in    = STEP_W'(step_ff + STEP_W'(1));
            if (step_ff == LOAD_LAST_STEP) begin
               state_in = ST_LOAD_DRAIN;
            end
         end
         ST_LOAD_DRAIN: begin
            state_in = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            ram_we   = 1'b1;
            state_in = ST_IDLE;
            priority if (pos_next >= cube_ff) begin
               pos_in = '0;
               l_in   = '0;
               r_in   = '0;
               c_in   = '0;
            end else begin
               pos_in = pos_next[POS_W-1:0];
               if (CMP_W'(c_ff) == CMP_W'(eff_last)) begin
                  c_in = '0;
                  if (CMP_W'(r_ff) == CMP_W'(eff_last)) begin
                     r_in = '0;
                     l_in = IDX_W'(l_ff + IDX_W'(1));
                  end else begin
                     r_in = IDX_W'(r_ff + IDX_W'(1));
                  end
               end else begin
                  c_in = IDX_W'(c_ff + IDX_W'(1));
               end
            end
         end
         ST_QUERY_RD: begin
            ram_re     = 1'b1;
            rd_pend_in = 1'b1;
            step_in    = STEP_W'(step_ff + STEP_W'(1));
            if (step_ff == QUERY_LAST_STEP) begin
               if (ly_ff == ly_end_ff) begin
                  state_in = ST_QUERY_DRAIN;
               end else begin
                  ly_in = IDX_W'(ly_ff + IDX_W'(1));
               end
            end
         end
         ST_QUERY_DRAIN: begin
            state_in = ST_QUERY_OUT;
         end
         ST_QUERY_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_total_in = bad_ff ? '0 : acc_ff;
               out_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= COORD_W'(SIDE);
         sq_ff        <= SQ_W'(SIDE * SIDE);
         cube_ff      <= CUBE_W'(DEPTH);
         settle_ff    <= '0;
         resync_ff    <= 1'b0;
         pos_ff       <= '0;
         l_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         sq_ff        <= sq_in;
         cube_ff      <= cube_in;
         settle_ff    <= settle_in;
         resync_ff    <= resync_in;
         pos_ff       <= pos_in;
         l_ff         <= l_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      acc_ff       <= acc_in;
      step_ff      <= step_in;
      ly_ff        <= ly_in;
      ly_end_ff    <= ly_end_in;
      rh_ff        <= rh_in;
      rl_ff        <= rl_in;
      ch_ff        <= ch_in;
      cl_ff        <= cl_in;
      rl_one_ff    <= rl_one_in;
      cl_one_ff    <= cl_one_in;
      bad_ff       <= bad_in;
      rd_zero_ff   <= rd_zero_in;
      rd_sub_ff    <= rd_sub_in;
      out_total_ff <= out_total_in;
      out_bad_ff   <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_total_ff);
   assign rsp_tuser  = out_bad_ff;

   `CRES_CHECK_NEXT(a_accept_leaves_idle, req_tvalid && req_tready,
      state_ff != ST_IDLE, "accepted request did not start a sequence")
   `CRES_CHECK_IMP(a_pos_matches_counters, !resync_ff,
      32'(pos_ff) == 32'(l_ff) * 32'(sq_ff) + 32'(r_ff) * 32'(eff) + 32'(c_ff),
      "load position and layer row column counters disagree")
   `CRES_CHECK_IMP(a_bad_gives_zero, rsp_tvalid && rsp_tuser,
      rsp_tdata == '0, "bad query returned a nonzero total")
   `CRES_CHECK_IMP(a_no_write_with_pending_read, rd_pend_ff,
      !ram_we, "prefix write while a read is still being summed")

endmodule
